@@ hdl/tcw_pkg.sv @@
// tcw_pkg: shared constants, command codes and the cell address function
// for the text console writer. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int NCELLS  = COLUMNS * ROWS;

   // Field widths
   localparam int ADDR_W  = $clog2(NCELLS);
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CELL_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int ACT_W   = 3;

   // Command codes
   localparam logic [ACT_W-1:0] ACT_PUT_CHAR  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_BACKSPACE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SET_CUR   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_PUT_AT    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ      = 3'd5;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

   // Register indexes
   localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
   localparam logic [1:0] REG_VIEW_TOP    = 2'd1;
   localparam logic [1:0] REG_VIEW_BOTTOM = 2'd2;

   // Register reset values
   localparam logic [7:0]       TEXT_COLOR_RST  = 8'h07;
   localparam logic [ROW_W-1:0] VIEW_TOP_RST    = '0;
   localparam logic [ROW_W-1:0] VIEW_BOTTOM_RST = ROW_W'(ROWS - 1);

   // Last row and column as field-width constants
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   // Linear store address of a cell: row * COLUMNS + col
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W+ROW_W-1:0] lin;
      lin = (ADDR_W+ROW_W)'(row) * (ADDR_W+ROW_W)'(COLUMNS) + (ADDR_W+ROW_W)'(col);
      return lin[ADDR_W-1:0];
   endfunction

endpackage

@@ hdl/tcw_ram.sv @@
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/text_console_writer.sv @@
// text_console_writer: top level, configuration registers, command sequencer
// and the cell store. Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

// Text console of 25 rows by 80 columns of 16-bit cells (attribute byte over
// character byte) with a cursor. After reset the block clears the cell store,
// one cell a cycle, and takes no item until that pass is done; configuration
// writes are taken throughout. One command is worked at a time, and every item
// goes through a small sequencer that drives a single address unit
// (row * 80 + col) and the one write and one read port of the cell store.
// Backspace and read cell pass through an extra state (the blank write or the
// read wait), unless the backspace does nothing. Clear and scroll sweep the
// viewport through the store ports, so that every cell of it is copied or
// blanked once. A waiting result does not stop the next item from entering;
// its own result waits until the output register is free.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   // Command items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_code, [14:8] col_in, [19:15] row_in, [23:20] cell_fg,
   // [27:24] cell_bg, [31:28] zero
   input  logic [31:0] req_tdata,
   // [2:0] action
   input  logic [2:0]  req_tuser,
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] cursor_row, [11:5] cursor_col, [27:12] cell_value, [31:28] zero
   output logic [31:0] rsp_tdata,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import tcw_pkg::*;

   // Sequencer states
   localparam logic [3:0] ST_INIT    = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_EXEC    = 4'd2;
   localparam logic [3:0] ST_BS_WR   = 4'd3;
   localparam logic [3:0] ST_START   = 4'd4;
   localparam logic [3:0] ST_BASE    = 4'd5;
   localparam logic [3:0] ST_COPY    = 4'd6;
   localparam logic [3:0] ST_FILL    = 4'd7;
   localparam logic [3:0] ST_RD_WAIT = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   // Control state
   logic [3:0]        state_ff, state_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [7:0]        text_color_ff, text_color_in;
   logic [ROW_W-1:0]  view_top_ff, view_top_in;
   logic [ROW_W-1:0]  view_bottom_ff, view_bottom_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              copy_vld_ff, copy_vld_in;

   // Payload state
   logic [ACT_W-1:0]  action_ff, action_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W-1:0]  col_req_ff, col_req_in;
   logic [ROW_W-1:0]  row_req_ff, row_req_in;
   logic [3:0]        fg_ff, fg_in;
   logic [3:0]        bg_ff, bg_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   // Store ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [CELL_W-1:0] ram_wd;
   logic [ADDR_W-1:0] ram_ra;
   logic [CELL_W-1:0] ram_rd;

   // Shared address unit
   logic [ROW_W-1:0]  au_row;
   logic [COL_W-1:0]  au_col;
   logic [ADDR_W-1:0] au_addr;

   // Viewport and helpers
   logic [ROW_W-1:0]  vp_bot, vp_top;
   logic [ROW_W-1:0]  cfg_bot, cfg_top;
   logic [CELL_W-1:0] blank_cell;
   logic              req_fire, cfg_wr, req_in_range, is_clear;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Effective viewport from the registers
   assign vp_bot = (view_bottom_ff < LAST_ROW) ? view_bottom_ff : LAST_ROW;
   assign vp_top = (view_top_ff < vp_bot) ? view_top_ff : vp_bot;

   // Viewport as it will be after a bottom write
   assign cfg_bot = (csr_pwdata[ROW_W-1:0] < LAST_ROW) ? csr_pwdata[ROW_W-1:0] : LAST_ROW;
   assign cfg_top = (view_top_ff < cfg_bot) ? view_top_ff : cfg_bot;

   assign blank_cell   = {text_color_ff, CH_BLANK};
   assign req_in_range = (row_req_ff <= LAST_ROW) && (col_req_ff <= LAST_COL);
   assign is_clear     = (action_ff == ACT_CLEAR);

   // Pick the operands of the address unit
   always_comb begin
      au_row = cur_row_ff;
      au_col = cur_col_ff;
      unique case (state_ff)
         ST_EXEC: begin
            if (action_ff == ACT_PUT_AT || action_ff == ACT_READ) begin
               au_row = row_req_ff;
               au_col = col_req_ff;
            end
         end
         ST_START: begin
            au_row = is_clear ? vp_top : vp_top + 1'b1;
            au_col = '0;
         end
         ST_BASE: begin
            au_row = vp_bot;
            au_col = '0;
         end
         default: begin
         end
      endcase
   end

   assign au_addr = cell_addr(au_row, au_col);

   // Sequencer and configuration
   always_comb begin
      state_in       = state_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      text_color_in  = text_color_ff;
      view_top_in    = view_top_ff;
      view_bottom_in = view_bottom_ff;
      rsp_valid_in   = rsp_valid_ff;
      addr_in        = addr_ff;
      copy_vld_in    = 1'b0;
      action_in      = action_ff;
      char_in        = char_ff;
      col_req_in     = col_req_ff;
      row_req_in     = row_req_ff;
      fg_in          = fg_ff;
      bg_in          = bg_ff;
      end_in         = end_ff;
      wr_addr_in     = wr_addr_ff;
      cell_in        = cell_ff;
      rsp_data_in    = rsp_data_ff;
      ram_we         = 1'b0;
      ram_wa         = addr_ff;
      ram_wd         = blank_cell;
      ram_ra         = addr_ff;

      // Drop the result once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; the bottom row write pulls the cursor into the viewport
      if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_TEXT_COLOR: text_color_in = csr_pwdata[7:0];
            REG_VIEW_TOP:   view_top_in   = csr_pwdata[ROW_W-1:0];
            REG_VIEW_BOTTOM: begin
               view_bottom_in = csr_pwdata[ROW_W-1:0];
               if (cur_row_ff < cfg_top) begin
                  cur_row_in = cfg_top;
               end else if (cur_row_ff > cfg_bot) begin
                  cur_row_in = cfg_bot;
               end
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         // Zero the store after reset
         ST_INIT: begin
            ram_we = 1'b1;
            ram_wa = addr_ff;
            ram_wd = '0;
            if (addr_ff == ADDR_W'(NCELLS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         // Latch the item
         ST_IDLE: begin
            if (req_fire) begin
               action_in  = req_tuser;
               char_in    = req_tdata[7:0];
               col_req_in = req_tdata[14:8];
               row_req_in = req_tdata[19:15];
               fg_in      = req_tdata[23:20];
               bg_in      = req_tdata[27:24];
               cell_in    = '0;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            case (action_ff)
               ACT_PUT_CHAR: begin
                  if (char_ff == CH_RETURN) begin
                     cur_col_in = '0;
                  end else begin
                     if (char_ff != CH_NEWLINE) begin
                        ram_we = 1'b1;
                        ram_wa = au_addr;
                        ram_wd = {text_color_ff, char_ff};
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                     // Newline, or wrap at the right edge
                     if (char_ff == CH_NEWLINE || cur_col_ff == LAST_COL) begin
                        cur_col_in = '0;
                        if (cur_row_ff >= vp_bot) begin
                           cur_row_in = vp_bot;
                           state_in   = ST_START;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end
                  end
               end
               ACT_BACKSPACE: begin
                  if (cur_col_ff == '0 && (cur_row_ff == vp_top || cur_row_ff == '0)) begin
                     state_in = ST_DONE;
                  end else begin
                     if (cur_col_ff == '0) begin
                        cur_row_in = cur_row_ff - 1'b1;
                        cur_col_in = LAST_COL;
                     end else begin
                        cur_col_in = cur_col_ff - 1'b1;
                     end
                     state_in = ST_BS_WR;
                  end
               end
               ACT_CLEAR: begin
                  cur_row_in = vp_top;
                  cur_col_in = '0;
                  state_in   = ST_START;
               end
               ACT_SET_CUR: begin
                  cur_col_in = (col_req_ff <= LAST_COL) ? col_req_ff : LAST_COL;
                  cur_row_in = (row_req_ff <= LAST_ROW) ? row_req_ff : LAST_ROW;
               end
               ACT_PUT_AT: begin
                  if (req_in_range) begin
                     ram_we = 1'b1;
                     ram_wa = au_addr;
                     ram_wd = {bg_ff, fg_ff, char_ff};
                  end
               end
               ACT_READ: begin
                  ram_ra   = au_addr;
                  state_in = ST_RD_WAIT;
               end
               default: begin
               end
            endcase
         end

         // Blank the cell the cursor moved back onto
         ST_BS_WR: begin
            ram_we   = 1'b1;
            ram_wa   = au_addr;
            ram_wd   = blank_cell;
            state_in = ST_DONE;
         end

         // First address of the sweep: copy source for scroll, top row for clear
         ST_START: begin
            addr_in  = au_addr;
            state_in = ST_BASE;
         end

         // Bottom row base; choose copy or fill
         ST_BASE: begin
            end_in = au_addr;
            if (is_clear) begin
               state_in = ST_FILL;
            end else if (vp_top < vp_bot) begin
               state_in = ST_COPY;
            end else begin
               addr_in  = au_addr;
               state_in = ST_FILL;
            end
         end

         // Move each row up by one: read one cell, write it a row higher next cycle;
         // the bottom row is the last one read, then the fill starts at its base
         ST_COPY: begin
            ram_we = copy_vld_ff;
            ram_wa = wr_addr_ff;
            ram_wd = ram_rd;
            if (addr_ff != end_ff + ADDR_W'(COLUMNS)) begin
               ram_ra      = addr_ff;
               copy_vld_in = 1'b1;
               wr_addr_in  = addr_ff - ADDR_W'(COLUMNS);
               addr_in     = addr_ff + 1'b1;
            end else begin
               addr_in  = end_ff;
               state_in = ST_FILL;
            end
         end

         // Blank cells up to the end of the bottom row
         ST_FILL: begin
            ram_we = 1'b1;
            ram_wa = addr_ff;
            ram_wd = blank_cell;
            if (addr_ff == end_ff + ADDR_W'(COLUMNS - 1)) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_RD_WAIT: begin
            cell_in  = req_in_range ? ram_rd : '0;
            state_in = ST_DONE;
         end

         // Hand the result to the output register when it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, cell_ff, cur_col_ff, cur_row_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         cur_row_ff     <= '0;
         cur_col_ff     <= '0;
         text_color_ff  <= TEXT_COLOR_RST;
         view_top_ff    <= VIEW_TOP_RST;
         view_bottom_ff <= VIEW_BOTTOM_RST;
         rsp_valid_ff   <= 1'b0;
         addr_ff        <= '0;
         copy_vld_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_row_ff     <= cur_row_in;
         cur_col_ff     <= cur_col_in;
         text_color_ff  <= text_color_in;
         view_top_ff    <= view_top_in;
         view_bottom_ff <= view_bottom_in;
         rsp_valid_ff   <= rsp_valid_in;
         addr_ff        <= addr_in;
         copy_vld_ff    <= copy_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      char_ff     <= char_in;
      col_req_ff  <= col_req_in;
      row_req_ff  <= row_req_in;
      fg_ff       <= fg_in;
      bg_ff       <= bg_in;
      end_ff      <= end_in;
      wr_addr_ff  <= wr_addr_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell store
   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(NCELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Register read back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TEXT_COLOR:  csr_prdata = {24'b0, text_color_ff};
         REG_VIEW_TOP:    csr_prdata = {27'b0, view_top_ff};
         REG_VIEW_BOTTOM: csr_prdata = {27'b0, view_bottom_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/tcw_checker.sv @@
// tcw_checker: port-level assertions for the text console writer, bound to
// the top level. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   import tcw_pkg::*;

   // Hold a result that has not been taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // Refuse items while the store is being cleared after reset
   a_init_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken during the clearing pass");

   // One command at a time: busy right after an item is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while a command is in progress");

   // Reported cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= LAST_ROW) && (rsp_tdata[11:5] <= LAST_COL))
      else $error("cursor reported off the screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
